// ----- design/chull_pkg.sv -----
package chull_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_W        = 30;
  localparam int KEY_W          = 2 * COORD_W;
  localparam int ACC_W          = 64;
  localparam int DIFF_W         = COORD_W + 1;
  localparam int IN_DATA_W      = 64;
  localparam int OUT_DATA_W     = 64;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_H_INIT,
    ST_H_NEXT,
    ST_H_RD,
    ST_SIFT,
    ST_SRD1,
    ST_SRD2,
    ST_SCMP,
    ST_E_INIT,
    ST_E_NEXT,
    ST_E_RD1,
    ST_E_RD2,
    ST_C_INIT,
    ST_C_NEXT,
    ST_C_RD,
    ST_C_TEST,
    ST_C_WAIT,
    ST_C_POPRD,
    ST_C_PUSH,
    ST_A_INIT,
    ST_A_RD0,
    ST_A_NEXT,
    ST_A_RD,
    ST_A_WAIT,
    ST_FIN
  } state_t;

  function automatic logic signed [COORD_W-1:0] key_coord(input logic [COORD_W-1:0] f);
    key_coord = $signed({~f[COORD_W-1], f[COORD_W-2:0]});
  endfunction

endpackage

// ----- design/chull_ram.sv -----
module chull_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- design/chull_cross.sv -----
module chull_cross
  import chull_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [KEY_W-1:0]        o,
  input  logic [KEY_W-1:0]        a,
  input  logic [KEY_W-1:0]        b,
  output logic                    done,
  output logic signed [ACC_W-1:0] res
);

  logic [1:0] step;
  logic       busy;
  logic signed [DIFF_W-1:0] dax, day, dbx, dby;
  logic signed [2*DIFF_W-1:0] p1, p2;
  logic signed [DIFF_W-1:0] ox, oy;

  assign ox = DIFF_W'(key_coord(o[KEY_W-1:COORD_W]));
  assign oy = DIFF_W'(key_coord(o[COORD_W-1:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dax <= DIFF_W'(key_coord(a[KEY_W-1:COORD_W])) - ox;
      day <= DIFF_W'(key_coord(a[COORD_W-1:0])) - oy;
      dbx <= DIFF_W'(key_coord(b[KEY_W-1:COORD_W])) - ox;
      dby <= DIFF_W'(key_coord(b[COORD_W-1:0])) - oy;
    end else if (busy) begin
      case (step)
        2'd0:    p1 <= dax * dby;
        2'd1:    p2 <= day * dbx;
        default: res <= ACC_W'(p1) - ACC_W'(p2);
      endcase
    end
  end

endmodule

// ----- design/convex_hull_area.sv -----
// Convex hull area of a set of points. Points arrive one transfer per cycle and are written
// to the point memory; the transfer with tlast closes the set. The block then heap-sorts
// the memory (roughly n*log2(n) sift levels in all), walks the lower and upper chains with
// a stack kept in a chain memory (at most 2n pushes and 2n pops) and sums twice the area
// over the chain, all through the single read port of each memory and one shared
// cross-product unit. No points are taken during that time, and the result of a set is
// issued only once the previous result has been taken. The result carries the whole part,
// a half flag and a flag that says points beyond MAX_POINTS were discarded.
module convex_hull_area
  import chull_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // point_x [29:0], point_y [59:30], zeros [63:60]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // area_whole [59:0], area_half [60], points_dropped [61], zeros [63:62]
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int CIDX_W = $clog2(2 * MAX_POINTS);
  localparam int CCNT_W = $clog2(2 * MAX_POINTS + 1);

  state_t state, state_next;

  logic [CNT_W-1:0]  count, i, r, len, k;
  logic [CNT_W:0]    c, bidx;
  logic              ovf, extract, upper;
  logic [KEY_W-1:0]  v, best, p, p0, top_p, second_p, prev, cur;
  logic [CCNT_W-1:0] base, mtot, j;
  logic [ACC_W-1:0]  acc, acc_abs;

  logic              st_we;
  logic [IDX_W-1:0]  st_waddr, st_raddr;
  logic [KEY_W-1:0]  st_wdata, st_rdata;
  logic              ch_we;
  logic [CIDX_W-1:0] ch_waddr, ch_raddr;
  logic [KEY_W-1:0]  ch_wdata, ch_rdata;
  logic              cx_start, cx_done;
  logic [KEY_W-1:0]  cx_o, cx_a, cx_b;
  logic signed [ACC_W-1:0] cx_res;

  logic s_fire, room;

  assign s_tready = (state == ST_LOAD);
  assign s_fire   = s_tvalid && s_tready;
  assign room     = (count < CNT_W'(MAX_POINTS));
  assign c        = {r, 1'b1};
  assign acc_abs  = acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;

  chull_ram #(.WIDTH(KEY_W), .DEPTH(MAX_POINTS), .AW(IDX_W)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  chull_ram #(.WIDTH(KEY_W), .DEPTH(2 * MAX_POINTS), .AW(CIDX_W)) u_chain (
    .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .raddr(ch_raddr), .rdata(ch_rdata)
  );

  chull_cross u_cross (
    .clk(clk), .rst(rst), .start(cx_start), .o(cx_o), .a(cx_a), .b(cx_b),
    .done(cx_done), .res(cx_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    st_we      = 1'b0;
    st_waddr   = '0;
    st_wdata   = v;
    st_raddr   = '0;
    ch_we      = 1'b0;
    ch_waddr   = '0;
    ch_wdata   = p;
    ch_raddr   = '0;
    cx_start   = 1'b0;
    cx_o       = second_p;
    cx_a       = top_p;
    cx_b       = p;
    case (state)
      ST_LOAD: begin
        if (s_fire) begin
          st_we    = room;
          st_waddr = count[IDX_W-1:0];
          st_wdata = {~s_tdata[29], s_tdata[28:0], ~s_tdata[59], s_tdata[58:30]};
          if (s_tlast) begin
            state_next = ST_H_INIT;
          end
        end
      end
      ST_H_INIT: state_next = ST_H_NEXT;
      ST_H_NEXT: begin
        if (i == '0) begin
          state_next = ST_E_INIT;
        end else begin
          st_raddr   = IDX_W'(i - CNT_W'(1));
          state_next = ST_H_RD;
        end
      end
      ST_H_RD: state_next = ST_SIFT;
      ST_SIFT: begin
        if (c >= {1'b0, len}) begin
          st_we      = 1'b1;
          st_waddr   = r[IDX_W-1:0];
          state_next = extract ? ST_E_NEXT : ST_H_NEXT;
        end else begin
          st_raddr   = c[IDX_W-1:0];
          state_next = ST_SRD1;
        end
      end
      ST_SRD1: begin
        if ((c + (CNT_W+1)'(1)) < {1'b0, len}) begin
          st_raddr   = IDX_W'(c + (CNT_W+1)'(1));
          state_next = ST_SRD2;
        end else begin
          state_next = ST_SCMP;
        end
      end
      ST_SRD2: state_next = ST_SCMP;
      ST_SCMP: begin
        st_we    = 1'b1;
        st_waddr = r[IDX_W-1:0];
        if (v >= best) begin
          state_next = extract ? ST_E_NEXT : ST_H_NEXT;
        end else begin
          st_wdata   = best;
          state_next = ST_SIFT;
        end
      end
      ST_E_INIT: state_next = ST_E_NEXT;
      ST_E_NEXT: begin
        if (i == '0) begin
          state_next = ST_C_INIT;
        end else begin
          st_raddr   = i[IDX_W-1:0];
          state_next = ST_E_RD1;
        end
      end
      ST_E_RD1: state_next = ST_E_RD2;
      ST_E_RD2: begin
        st_we      = 1'b1;
        st_waddr   = i[IDX_W-1:0];
        st_wdata   = st_rdata;
        state_next = ST_SIFT;
      end
      ST_C_INIT: state_next = ST_C_NEXT;
      ST_C_NEXT: begin
        if (!upper && i == count) begin
          state_next = ST_C_NEXT;
        end else if (upper && i == '0) begin
          state_next = ST_A_INIT;
        end else begin
          st_raddr   = upper ? IDX_W'(i - CNT_W'(1)) : i[IDX_W-1:0];
          state_next = ST_C_RD;
        end
      end
      ST_C_RD: state_next = ST_C_TEST;
      ST_C_TEST: begin
        if (k >= CNT_W'(2)) begin
          cx_start   = 1'b1;
          state_next = ST_C_WAIT;
        end else begin
          state_next = ST_C_PUSH;
        end
      end
      ST_C_WAIT: begin
        if (cx_done) begin
          if (cx_res > 0) begin
            state_next = ST_C_PUSH;
          end else if (k >= CNT_W'(3)) begin
            ch_raddr   = CIDX_W'(base + CCNT_W'(k) - CCNT_W'(3));
            state_next = ST_C_POPRD;
          end else begin
            state_next = ST_C_TEST;
          end
        end
      end
      ST_C_POPRD: state_next = ST_C_TEST;
      ST_C_PUSH: begin
        ch_we      = 1'b1;
        ch_waddr   = CIDX_W'(base + CCNT_W'(k));
        state_next = ST_C_NEXT;
      end
      ST_A_INIT: state_next = ST_A_RD0;
      ST_A_RD0:  state_next = ST_A_NEXT;
      ST_A_NEXT: begin
        if (j == mtot) begin
          state_next = ST_FIN;
        end else begin
          ch_raddr   = j[CIDX_W-1:0];
          state_next = ST_A_RD;
        end
      end
      ST_A_RD: begin
        cx_start   = 1'b1;
        cx_o       = p0;
        cx_a       = prev;
        cx_b       = ch_rdata;
        state_next = ST_A_WAIT;
      end
      ST_A_WAIT: begin
        if (cx_done) begin
          state_next = ST_A_NEXT;
        end
      end
      ST_FIN: begin
        if (!m_tvalid) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (s_fire) begin
            if (room) begin
              count <= count + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        ST_FIN: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            count    <= '0;
            ovf      <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_H_INIT: begin
        i       <= count >> 1;
        extract <= 1'b0;
      end
      ST_H_NEXT: r <= i - CNT_W'(1);
      ST_H_RD: begin
        v   <= st_rdata;
        len <= count;
      end
      ST_SIFT: begin
        if (c >= {1'b0, len}) begin
          i <= i - CNT_W'(1);
        end
      end
      ST_SRD1: begin
        best <= st_rdata;
        bidx <= c;
      end
      ST_SRD2: begin
        if (st_rdata > best) begin
          best <= st_rdata;
          bidx <= c + (CNT_W+1)'(1);
        end
      end
      ST_SCMP: begin
        if (v >= best) begin
          i <= i - CNT_W'(1);
        end else begin
          r <= bidx[CNT_W-1:0];
        end
      end
      ST_E_INIT: begin
        i       <= count - CNT_W'(1);
        extract <= 1'b1;
      end
      ST_E_RD1: v <= st_rdata;
      ST_E_RD2: begin
        r   <= '0;
        len <= i;
      end
      ST_C_INIT: begin
        i     <= '0;
        k     <= '0;
        base  <= '0;
        upper <= 1'b0;
      end
      ST_C_NEXT: begin
        if (!upper && i == count) begin
          upper <= 1'b1;
          base  <= CCNT_W'(k);
          k     <= '0;
          i     <= count;
        end else if (upper && i == '0) begin
          mtot <= base + CCNT_W'(k);
        end
      end
      ST_C_RD: begin
        p <= st_rdata;
        if (!upper && i == '0) begin
          p0 <= st_rdata;
        end
      end
      ST_C_WAIT: begin
        if (cx_done && !(cx_res > 0)) begin
          k     <= k - CNT_W'(1);
          top_p <= second_p;
        end
      end
      ST_C_POPRD: second_p <= ch_rdata;
      ST_C_PUSH: begin
        second_p <= top_p;
        top_p    <= p;
        k        <= k + CNT_W'(1);
        i        <= upper ? (i - CNT_W'(1)) : (i + CNT_W'(1));
      end
      ST_A_INIT: acc <= '0;
      ST_A_RD0: begin
        prev <= ch_rdata;
        j    <= CCNT_W'(1);
      end
      ST_A_RD: cur <= ch_rdata;
      ST_A_WAIT: begin
        if (cx_done) begin
          acc  <= acc + ACC_W'(cx_res);
          prev <= cur;
          j    <= j + CCNT_W'(1);
        end
      end
      ST_FIN: begin
        if (!m_tvalid) begin
          m_tdata <= {2'b00, ovf, acc_abs[0], acc_abs[60:1]};
        end
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("Point count exceeds the store depth.");

  a_cross_done: assert property (@(posedge clk) disable iff (rst)
    cx_done |-> (state == ST_C_WAIT || state == ST_A_WAIT))
    else $error("Cross product finished outside a wait state.");

  a_fin_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && !m_tvalid) |=> (count == '0 && m_tvalid && state == ST_LOAD))
    else $error("Result issue did not clear the set.");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_LOAD && state != ST_FIN) |=> $stable(count))
    else $error("Point count changed during computation.");

endmodule
